@@ rtl/core/quadratic_escape_time_iterator_assert.svh @@
// ----------------------------------------------------------------------------
// quadratic escape time iterator assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ESCAPE_TIME_ITERATOR_ASSERT_SVH
`define QUADRATIC_ESCAPE_TIME_ITERATOR_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define QETI_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define QETI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/qeti_pkg.sv @@
// ----------------------------------------------------------------------------
// qeti_pkg
// widths, operation codes and controller/datapath link types
// ----------------------------------------------------------------------------
package qeti_pkg;

   localparam int FRAC_BITS_DEF = 28;
   localparam int POINT_W       = 32;
   localparam int COUNT_W       = 16;
   localparam int ZW            = 64;   // z component width
   localparam int PW            = 128;  // full product width
   localparam int MUL_W         = 32;   // multiplier operand width
   localparam int PROD_W        = 2 * MUL_W;
   localparam int PART_W        = 2;    // four partial products per 64x64 product

   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd1500;

   typedef logic [1:0] op_type;

   localparam op_type OP_CROSS = 2'd0;  // zr * zi
   localparam op_type OP_SQR_R = 2'd1;  // zr * zr
   localparam op_type OP_SQR_I = 2'd2;  // zi * zi

   typedef struct packed {
      logic              load;    // capture c, clear z and squares
      logic              issue;   // start one partial product
      op_type            op;
      logic [PART_W-1:0] part;    // {high half of a, high half of b}
      logic              update;  // z = z*z + c
   } dp_cmd_type;

   typedef struct packed {
      logic escape;               // |z|^2 > 4
   } dp_status_type;

endpackage

@@ rtl/core/qeti_if.sv @@
// ----------------------------------------------------------------------------
// qeti channel interfaces
// valid/ready channels for points in and escape counts out
// ----------------------------------------------------------------------------
interface qeti_req_if import qeti_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_real;
   logic signed [POINT_W-1:0] point_imag;

   modport source (output valid, output point_real, output point_imag, input ready);
   modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

interface qeti_rsp_if import qeti_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] escape_count;

   modport source (output valid, output escape_count, input ready);
   modport sink   (input valid, input escape_count, output ready);
endinterface

@@ rtl/core/qeti_datapath.sv @@
// ----------------------------------------------------------------------------
// qeti_datapath
// z registers, shared 32x32 multiplier with accumulator, update and escape test
// ----------------------------------------------------------------------------
module qeti_datapath import qeti_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   input  logic signed [POINT_W-1:0] point_real,
   input  logic signed [POINT_W-1:0] point_imag,
   output dp_status_type             status
);

   localparam logic [PW-1:0] LIMIT = {{(PW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

   logic [POINT_W-1:0] cr_ff, ci_ff, cr_in, ci_in;
   logic [ZW-1:0]      zr_ff, zi_ff, zr_in, zi_in;
   logic [ZW-1:0]      mag_r_ff, mag_i_ff;
   logic [PW-1:0]      sr_ff, si_ff, cross_ff, sr_in, si_in, cross_in;
   logic [PW-1:0]      diff_ff, sum_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               p_valid_ff, p_first_ff, p_neg_ff;
   logic [1:0]         p_shift_ff;
   op_type             p_op_ff;

   logic [ZW-1:0]      opnd_a, opnd_b;
   logic [MUL_W-1:0]   half_a, half_b;
   logic [PW-1:0]      term, acc_base, acc_new;
   logic [ZW-1:0]      cr_ext, ci_ext;

   // operand select and one 32x32 partial product
   always_comb begin
      unique case (cmd.op)
         OP_CROSS: begin opnd_a = mag_r_ff; opnd_b = mag_i_ff; end
         OP_SQR_R: begin opnd_a = mag_r_ff; opnd_b = mag_r_ff; end
         OP_SQR_I: begin opnd_a = mag_i_ff; opnd_b = mag_i_ff; end
         default:  begin opnd_a = '0;       opnd_b = '0;       end
      endcase
      half_a  = cmd.part[1] ? opnd_a[ZW-1:MUL_W] : opnd_a[MUL_W-1:0];
      half_b  = cmd.part[0] ? opnd_b[ZW-1:MUL_W] : opnd_b[MUL_W-1:0];
      prod_in = PROD_W'(half_a) * PROD_W'(half_b);
   end

   // accumulate the registered partial product into its destination
   always_comb begin
      term = PW'(prod_ff) << {p_shift_ff, 5'b0};
      unique case (p_op_ff)
         OP_CROSS: acc_base = cross_ff;
         OP_SQR_R: acc_base = sr_ff;
         OP_SQR_I: acc_base = si_ff;
         default:  acc_base = '0;
      endcase
      if (p_first_ff) begin
         acc_base = '0;
      end
      acc_new = p_neg_ff ? (acc_base - term) : (acc_base + term);
   end

   assign cr_ext = {{(ZW-POINT_W){cr_ff[POINT_W-1]}}, cr_ff};
   assign ci_ext = {{(ZW-POINT_W){ci_ff[POINT_W-1]}}, ci_ff};

   always_comb begin
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      sr_in    = sr_ff;
      si_in    = si_ff;
      cross_in = cross_ff;
      if (cmd.load) begin
         cr_in = point_real;
         ci_in = point_imag;
         zr_in = '0;
         zi_in = '0;
         sr_in = '0;
         si_in = '0;
      end else begin
         if (cmd.update) begin
            // floor division by 2^frac is the arithmetic part-select
            zr_in = diff_ff[FRAC_BITS +: ZW] + cr_ext;
            zi_in = cross_ff[FRAC_BITS-1 +: ZW] + ci_ext;
         end
         if (p_valid_ff) begin
            unique case (p_op_ff)
               OP_CROSS: cross_in = acc_new;
               OP_SQR_R: sr_in    = acc_new;
               OP_SQR_I: si_in    = acc_new;
               default:  cross_in = cross_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff      <= cr_in;
      ci_ff      <= ci_in;
      zr_ff      <= zr_in;
      zi_ff      <= zi_in;
      sr_ff      <= sr_in;
      si_ff      <= si_in;
      cross_ff   <= cross_in;
      mag_r_ff   <= zr_ff[ZW-1] ? ('0 - zr_ff) : zr_ff;
      mag_i_ff   <= zi_ff[ZW-1] ? ('0 - zi_ff) : zi_ff;
      diff_ff    <= sr_ff - si_ff;
      sum_ff     <= sr_ff + si_ff;
      prod_ff    <= prod_in;
      p_first_ff <= (cmd.part == '0);
      p_shift_ff <= {1'b0, cmd.part[1]} + {1'b0, cmd.part[0]};
      p_op_ff    <= cmd.op;
      p_neg_ff   <= (cmd.op == OP_CROSS) && (zr_ff[ZW-1] ^ zi_ff[ZW-1]);
   end

   assign status.escape = (sum_ff > LIMIT);

endmodule

@@ rtl/core/qeti_controller.sv @@
// ----------------------------------------------------------------------------
// qeti_controller
// iteration sequencer: multiplier steps, update, escape test and result hand-off
// ----------------------------------------------------------------------------
`include "quadratic_escape_time_iterator_assert.svh"

module qeti_controller import qeti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COUNT_W-1:0] max_iterations,
   input  logic               out_free,
   output logic               result_load,
   output logic [COUNT_W-1:0] result_count,
   output dp_cmd_type         cmd,
   input  dp_status_type      status
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_HEAD   = 4'd1;
   localparam logic [3:0] S_CROSS  = 4'd2;
   localparam logic [3:0] S_UPDATE = 4'd3;
   localparam logic [3:0] S_MAG    = 4'd4;
   localparam logic [3:0] S_SQR_R  = 4'd5;
   localparam logic [3:0] S_SQR_I  = 4'd6;
   localparam logic [3:0] S_SUM    = 4'd7;
   localparam logic [3:0] S_TEST   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   // four issue steps, then one step to drain the last partial product
   localparam logic [2:0] STEP_LAST = 3'd4;

   logic [3:0]         state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [COUNT_W-1:0] k_ff, k_in;
   logic [COUNT_W-1:0] result_ff, result_in;
   logic               mul_state;

   assign req_ready    = (state_ff == S_IDLE);
   assign result_count = result_ff;
   assign mul_state    = (state_ff == S_CROSS) || (state_ff == S_SQR_R) ||
                         (state_ff == S_SQR_I);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      k_in        = k_ff;
      result_in   = result_ff;
      result_load = 1'b0;
      cmd         = '0;
      cmd.part    = step_ff[PART_W-1:0];
      cmd.issue   = mul_state && (step_ff != STEP_LAST);

      unique case (state_ff)
         S_SQR_R: cmd.op = OP_SQR_R;
         S_SQR_I: cmd.op = OP_SQR_I;
         default: cmd.op = OP_CROSS;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               k_in     = {{(COUNT_W-1){1'b0}}, 1'b1};
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (k_ff >= max_iterations) begin
               result_in = '0;
               state_in  = S_DONE;
            end else begin
               step_in  = '0;
               state_in = S_CROSS;
            end
         end
         S_CROSS, S_SQR_R, S_SQR_I: begin
            if (step_ff == STEP_LAST) begin
               step_in = '0;
               unique case (state_ff)
                  S_CROSS: state_in = S_UPDATE;
                  S_SQR_R: state_in = S_SQR_I;
                  default: state_in = S_SUM;
               endcase
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_MAG;
         end
         S_MAG:  state_in = S_SQR_R;
         S_SUM:  state_in = S_TEST;
         S_TEST: begin
            if (status.escape) begin
               result_in = k_ff;
               state_in  = S_DONE;
            end else begin
               k_in     = k_ff + {{(COUNT_W-1){1'b0}}, 1'b1};
               state_in = S_HEAD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               result_load = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   `QETI_ASSERT_SAME(a_load_needs_room, result_load, out_free, "result loaded over a held result")
   `QETI_ASSERT_SAME(a_count_below_limit, result_load && (result_ff != '0), result_ff < max_iterations, "escape count not below limit")
   `QETI_ASSERT_NEXT(a_count_steps, (state_ff == S_TEST) && !status.escape, k_ff == $past(k_ff) + 16'd1, "iteration count did not advance")
   `QETI_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, (state_ff == S_HEAD) && (k_ff == 16'd1), "accepted point did not start at iteration one")

endmodule

@@ rtl/core/quadratic_escape_time_iterator.sv @@
// ----------------------------------------------------------------------------
// quadratic_escape_time_iterator
// escape-time count of z = z*z + c for one Q4.28 point per transaction
// ----------------------------------------------------------------------------
// usage
//   req_if  : valid/ready sink carrying point_real and point_imag (signed, c)
//   rsp_if  : valid/ready source carrying escape_count (0 when bounded)
//   csr_*   : write-only iteration limit, write only while the block is idle
// timing
//   a point is taken only while the sequencer is idle; one point at a time
//   each iteration: one 32x32 multiplier builds the cross product and both
//   64-bit squares from four partial products each, plus update, magnitude,
//   sum, escape test and loop head
//   the next point can be taken in the same cycle that rsp valid rises
// reset and stall
//   synchronous reset returns to idle, drops rsp valid, limit back to 1500
//   the result sits in an output register; the next point is accepted while it
//   waits, and only the hand-off of the following result stalls on rsp ready
// ----------------------------------------------------------------------------
module quadratic_escape_time_iterator import qeti_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   qeti_req_if.sink           req_if,
   qeti_rsp_if.source         rsp_if,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data
);

   logic [COUNT_W-1:0] max_iter_ff;     // iteration limit register
   logic               rsp_valid_ff;    // output register holds a result
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               out_free;        // output register can take a result
   logic               result_load;
   logic [COUNT_W-1:0] result_count;
   dp_cmd_type         cmd;
   dp_status_type      status;

   // free when empty, or when its result leaves this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // sequencer: loop count, multiplier steps, result hand-off
   qeti_controller u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .max_iterations (max_iter_ff),
      .out_free       (out_free),
      .result_load    (result_load),
      .result_count   (result_count),
      .cmd            (cmd),
      .status         (status)
   );

   // arithmetic: z, squares, cross product, escape compare
   qeti_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .point_real (req_if.point_real),
      .point_imag (req_if.point_imag),
      .status     (status)
   );

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_write_enable) begin
         max_iter_ff <= csr_write_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_count_ff <= result_count;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.escape_count = rsp_count_ff;

endmodule
